// File: design/sba_pkg.sv
// Shared types, constants and helpers for the subpage buddy allocator.
// Used by sba_slot_ram and subpage_buddy_allocator; depends on nothing else.
`timescale 1ns / 1ps

package sba_pkg;

	localparam int TOP_LEVEL       = 7;
	localparam int POOL_PAGES      = 16;
	localparam int MIN_BLOCK_BYTES = 32;

	localparam int OFF_W      = $clog2(MIN_BLOCK_BYTES);
	localparam int PAGE_W     = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
	localparam int SLOT_W     = $clog2(POOL_PAGES) + TOP_LEVEL;
	localparam int LINK_W     = SLOT_W + 1;
	localparam int NUM_SLOTS  = POOL_PAGES << TOP_LEVEL;
	localparam int PAGE_BYTES = MIN_BLOCK_BYTES << TOP_LEVEL;
	localparam int LVL_W      = 3;
	localparam int ADDR_W     = 16;
	localparam int SIZE_W     = 13;
	localparam int CNT_W      = 5;

	localparam logic [LINK_W-1:0] NO_LINK = LINK_W'(NUM_SLOTS);

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FR_CHK,
		ST_MERGE,
		ST_FR_BUD,
		ST_UL_DATA,
		ST_UL_N,
		ST_UL_P,
		ST_SPLIT,
		ST_PUSH,
		ST_PUSH_H,
		ST_DONE
	} state_t;

	typedef enum logic {
		REQ_ALLOC = 1'b0,
		REQ_FREE  = 1'b1
	} req_kind_t;

	typedef enum logic {
		STAT_DONE = 1'b0,
		STAT_OOM  = 1'b1
	} status_t;

	typedef struct packed {
		logic              req_type;
		logic [SIZE_W-1:0] req_size;
		logic [ADDR_W-1:0] free_addr;
	} req_t;

	typedef struct packed {
		logic              status;
		logic [ADDR_W-1:0] block_addr;
		logic [LVL_W-1:0]  block_level;
		logic [CNT_W-1:0]  pages_in_use;
	} res_t;

	// One entry per slot: flags, the level of the block that starts there and
	// the free-list links.
	typedef struct packed {
		logic              is_free;
		logic              is_alloc;
		logic [LVL_W-1:0]  level;
		logic [LINK_W-1:0] prev;
		logic [LINK_W-1:0] next;
	} slot_word_t;

	typedef struct packed {
		logic              rd_en;
		logic [SLOT_W-1:0] rd_addr;
		logic              wr_en;
		logic [SLOT_W-1:0] wr_addr;
		slot_word_t        wr_data;
	} ram_req_t;

	// Smallest level whose block holds the size; sizes above a page give TOP_LEVEL.
	function automatic logic [LVL_W-1:0] size_level(input logic [SIZE_W-1:0] size);
		logic [LVL_W-1:0] lv;
		lv = LVL_W'(TOP_LEVEL);
		for (int i = TOP_LEVEL - 1; i >= 0; i--) begin
			if (32'(size) <= (32'(MIN_BLOCK_BYTES) << i))
				lv = LVL_W'(i);
		end
		return lv;
	endfunction

	function automatic logic link_valid(input logic [LINK_W-1:0] l);
		return l < NO_LINK;
	endfunction

endpackage

// File: design/sba_slot_ram.sv
// Slot table of the subpage buddy allocator: one write and one read port,
// read data registered and held until the next read. Uses sba_pkg.
`timescale 1ns / 1ps

module sba_slot_ram (
	input  logic                clk,
	input  sba_pkg::ram_req_t   req,
	output sba_pkg::slot_word_t rdata
);

	sba_pkg::slot_word_t mem [sba_pkg::NUM_SLOTS];

	always_ff @(posedge clk) begin
		if (req.wr_en)
			mem[req.wr_addr] <= req.wr_data;
		if (req.rd_en)
			rdata <= mem[req.rd_addr];
	end

endmodule

// File: design/subpage_buddy_allocator.sv
// Subpage buddy allocator top level: request sequencer, free-list heads,
// page pool and result register. Uses sba_pkg and sba_slot_ram.
//
//   channel | direction | payload             | handshake
//   in      | input     | in_data  (req_t)    | in_valid / in_stall
//   out     | output    | out_data (res_t)    | out_valid / out_stall
//
// The length of each request is set by the single slot-table port, through which
// every unlink and every push goes. After reset a clearing pass writes all
// NUM_SLOTS entries while in_stall is high. A result waits in the output
// register; a new request is taken while it waits, and the sequencer holds
// only if a second result is due.
`timescale 1ns / 1ps

module subpage_buddy_allocator (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  sba_pkg::req_t   in_data,
	output logic            out_valid,
	input  logic            out_stall,
	output sba_pkg::res_t   out_data
);

	localparam int SW = sba_pkg::SLOT_W;
	localparam int LW = sba_pkg::LINK_W;
	localparam int VW = sba_pkg::LVL_W;

	sba_pkg::state_t state_q, state_d;

	logic                          op_free_q, op_free_d;
	logic [SW-1:0]                 s_q, s_d;
	logic [VW-1:0]                 lv_q, lv_d;
	logic [VW-1:0]                 k_q, k_d;
	logic [SW-1:0]                 ul_slot_q, ul_slot_d;
	logic [VW-1:0]                 ul_lvl_q, ul_lvl_d;
	logic [LW-1:0]                 n_q, n_d, p_q, p_d;
	logic [SW-1:0]                 push_slot_q, push_slot_d;
	logic [VW-1:0]                 push_lvl_q, push_lvl_d;
	logic [SW-1:0]                 hd_q, hd_d;
	logic [SW-1:0]                 head_q [sba_pkg::TOP_LEVEL];
	logic [SW-1:0]                 head_d [sba_pkg::TOP_LEVEL];
	logic [sba_pkg::TOP_LEVEL-1:0] nonempty_q, nonempty_d;
	logic [sba_pkg::POOL_PAGES-1:0] page_map_q, page_map_d;
	logic [sba_pkg::CNT_W-1:0]     page_count_q, page_count_d;
	logic                          res_status_q, res_status_d;
	logic [sba_pkg::ADDR_W-1:0]    res_addr_q, res_addr_d;
	logic [VW-1:0]                 res_level_q, res_level_d;
	logic                          out_valid_q, out_valid_d;
	sba_pkg::res_t                 out_q, out_d;
	logic [SW-1:0]                 clr_cnt_q, clr_cnt_d;

	sba_pkg::ram_req_t   ram_req;
	sba_pkg::slot_word_t rdata;

	sba_slot_ram u_ram (
		.clk   (clk),
		.req   (ram_req),
		.rdata (rdata)
	);

	assign in_stall  = (state_q != sba_pkg::ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		logic [VW-1:0]     lv;
		logic [VW-1:0]     j;
		logic              j_found;
		logic [sba_pkg::PAGE_W-1:0] pg;
		logic              pg_found;
		logic [SW-1:0]     bud;
		logic              back_to_split;
		sba_pkg::slot_word_t w;

		state_d      = state_q;
		op_free_d    = op_free_q;
		s_d          = s_q;
		lv_d         = lv_q;
		k_d          = k_q;
		ul_slot_d    = ul_slot_q;
		ul_lvl_d     = ul_lvl_q;
		n_d          = n_q;
		p_d          = p_q;
		push_slot_d  = push_slot_q;
		push_lvl_d   = push_lvl_q;
		hd_d         = hd_q;
		head_d       = head_q;
		nonempty_d   = nonempty_q;
		page_map_d   = page_map_q;
		page_count_d = page_count_q;
		res_status_d = res_status_q;
		res_addr_d   = res_addr_q;
		res_level_d  = res_level_q;
		out_d        = out_q;
		out_valid_d  = out_valid_q;
		clr_cnt_d    = clr_cnt_q;
		ram_req      = '0;
		lv           = '0;
		j            = '0;
		j_found      = 1'b0;
		pg           = '0;
		pg_found     = 1'b0;
		bud          = '0;
		back_to_split = 1'b0;
		w            = '0;

		if (out_valid_q && !out_stall)
			out_valid_d = 1'b0;

		unique case (state_q)
			sba_pkg::ST_CLEAR: begin
				ram_req.wr_en   = 1'b1;
				ram_req.wr_addr = clr_cnt_q;
				clr_cnt_d       = clr_cnt_q + 1'b1;
				if (clr_cnt_q == SW'(sba_pkg::NUM_SLOTS - 1))
					state_d = sba_pkg::ST_IDLE;
			end

			sba_pkg::ST_IDLE: begin
				if (in_valid) begin
					op_free_d    = (in_data.req_type == sba_pkg::REQ_FREE);
					res_status_d = sba_pkg::STAT_DONE;
					res_addr_d   = '0;
					res_level_d  = '0;
					if (in_data.req_type == sba_pkg::REQ_ALLOC) begin
						lv           = sba_pkg::size_level(in_data.req_size);
						lv_d         = lv;
						res_level_d  = lv;
						res_status_d = sba_pkg::STAT_OOM;
						// Smallest nonempty list at or above the requested level.
						for (int i = sba_pkg::TOP_LEVEL - 1; i >= 0; i--) begin
							if (nonempty_q[i] && VW'(i) >= lv) begin
								j       = VW'(i);
								j_found = 1'b1;
							end
						end
						for (int i = sba_pkg::POOL_PAGES - 1; i >= 0; i--) begin
							if (!page_map_q[i]) begin
								pg       = sba_pkg::PAGE_W'(i);
								pg_found = 1'b1;
							end
						end
						if (32'(in_data.req_size) > 32'(sba_pkg::PAGE_BYTES)) begin
							state_d = sba_pkg::ST_DONE;
						end else if (j_found) begin
							s_d             = head_q[j];
							ul_slot_d       = head_q[j];
							ul_lvl_d        = j;
							k_d             = j;
							ram_req.rd_en   = 1'b1;
							ram_req.rd_addr = head_q[j];
							state_d         = sba_pkg::ST_UL_DATA;
						end else if (pg_found) begin
							page_map_d[pg] = 1'b1;
							page_count_d   = page_count_q + 1'b1;
							s_d            = SW'(pg) << sba_pkg::TOP_LEVEL;
							k_d            = VW'(sba_pkg::TOP_LEVEL);
							state_d        = sba_pkg::ST_SPLIT;
						end else begin
							state_d = sba_pkg::ST_DONE;
						end
					end else begin
						if (in_data.free_addr[sba_pkg::OFF_W-1:0] != '0) begin
							state_d = sba_pkg::ST_DONE;
						end else begin
							s_d             = in_data.free_addr[sba_pkg::OFF_W +: SW];
							ram_req.rd_en   = 1'b1;
							ram_req.rd_addr = in_data.free_addr[sba_pkg::OFF_W +: SW];
							state_d         = sba_pkg::ST_FR_CHK;
						end
					end
				end
			end

			sba_pkg::ST_FR_CHK: begin
				if (!rdata.is_alloc) begin
					state_d = sba_pkg::ST_DONE;
				end else begin
					w               = rdata;
					w.is_alloc      = 1'b0;
					ram_req.wr_en   = 1'b1;
					ram_req.wr_addr = s_q;
					ram_req.wr_data = w;
					lv_d            = rdata.level;
					res_level_d     = rdata.level;
					state_d         = sba_pkg::ST_MERGE;
				end
			end

			sba_pkg::ST_MERGE: begin
				if (lv_q >= VW'(sba_pkg::TOP_LEVEL)) begin
					// Fully merged or whole-page block: the page goes back to the pool.
					pg = s_q[SW-1 -: sba_pkg::PAGE_W];
					if (page_map_q[pg]) begin
						page_map_d[pg] = 1'b0;
						if (page_count_q != '0)
							page_count_d = page_count_q - 1'b1;
					end
					state_d = sba_pkg::ST_DONE;
				end else begin
					ram_req.rd_en   = 1'b1;
					ram_req.rd_addr = s_q ^ (SW'(1) << lv_q);
					state_d         = sba_pkg::ST_FR_BUD;
				end
			end

			sba_pkg::ST_FR_BUD: begin
				bud = s_q ^ (SW'(1) << lv_q);
				if (rdata.is_free && rdata.level == lv_q) begin
					ul_slot_d = bud;
					ul_lvl_d  = lv_q;
					s_d       = s_q & ~(SW'(1) << lv_q);
					lv_d      = lv_q + 1'b1;
					state_d   = sba_pkg::ST_UL_DATA;
				end else begin
					push_slot_d = s_q;
					push_lvl_d  = lv_q;
					state_d     = sba_pkg::ST_PUSH;
				end
			end

			sba_pkg::ST_UL_DATA: begin
				// The read data still holds the entry being taken off its list.
				w               = rdata;
				w.is_free       = 1'b0;
				ram_req.wr_en   = 1'b1;
				ram_req.wr_addr = ul_slot_q;
				ram_req.wr_data = w;
				n_d             = rdata.next;
				p_d             = rdata.prev;
				if (!sba_pkg::link_valid(rdata.prev)) begin
					head_d[ul_lvl_q]     = sba_pkg::link_valid(rdata.next) ?
						rdata.next[SW-1:0] : '0;
					nonempty_d[ul_lvl_q] = sba_pkg::link_valid(rdata.next);
				end
				if (sba_pkg::link_valid(rdata.next)) begin
					ram_req.rd_en   = 1'b1;
					ram_req.rd_addr = rdata.next[SW-1:0];
					state_d         = sba_pkg::ST_UL_N;
				end else if (sba_pkg::link_valid(rdata.prev)) begin
					ram_req.rd_en   = 1'b1;
					ram_req.rd_addr = rdata.prev[SW-1:0];
					state_d         = sba_pkg::ST_UL_P;
				end else begin
					back_to_split = 1'b1;
				end
			end

			sba_pkg::ST_UL_N: begin
				w               = rdata;
				w.prev          = p_q;
				ram_req.wr_en   = 1'b1;
				ram_req.wr_addr = n_q[SW-1:0];
				ram_req.wr_data = w;
				if (sba_pkg::link_valid(p_q)) begin
					ram_req.rd_en   = 1'b1;
					ram_req.rd_addr = p_q[SW-1:0];
					state_d         = sba_pkg::ST_UL_P;
				end else begin
					back_to_split = 1'b1;
				end
			end

			sba_pkg::ST_UL_P: begin
				w               = rdata;
				w.next          = n_q;
				ram_req.wr_en   = 1'b1;
				ram_req.wr_addr = p_q[SW-1:0];
				ram_req.wr_data = w;
				back_to_split   = 1'b1;
			end

			sba_pkg::ST_SPLIT: begin
				if (k_q > lv_q) begin
					push_slot_d = s_q | (SW'(1) << (k_q - 1'b1));
					push_lvl_d  = k_q - 1'b1;
					k_d         = k_q - 1'b1;
					state_d     = sba_pkg::ST_PUSH;
				end else begin
					w.is_alloc      = 1'b1;
					w.level         = lv_q;
					ram_req.wr_en   = 1'b1;
					ram_req.wr_addr = s_q;
					ram_req.wr_data = w;
					res_status_d    = sba_pkg::STAT_DONE;
					res_addr_d      = sba_pkg::ADDR_W'(s_q) << sba_pkg::OFF_W;
					state_d         = sba_pkg::ST_DONE;
				end
			end

			sba_pkg::ST_PUSH: begin
				w.is_free = 1'b1;
				w.level   = push_lvl_q;
				w.prev    = sba_pkg::NO_LINK;
				w.next    = nonempty_q[push_lvl_q] ? LW'(head_q[push_lvl_q]) : sba_pkg::NO_LINK;
				ram_req.wr_en   = 1'b1;
				ram_req.wr_addr = push_slot_q;
				ram_req.wr_data = w;
				head_d[push_lvl_q]     = push_slot_q;
				nonempty_d[push_lvl_q] = 1'b1;
				if (nonempty_q[push_lvl_q]) begin
					ram_req.rd_en   = 1'b1;
					ram_req.rd_addr = head_q[push_lvl_q];
					hd_d            = head_q[push_lvl_q];
					state_d         = sba_pkg::ST_PUSH_H;
				end else begin
					state_d = op_free_q ? sba_pkg::ST_DONE : sba_pkg::ST_SPLIT;
				end
			end

			sba_pkg::ST_PUSH_H: begin
				w               = rdata;
				w.prev          = LW'(push_slot_q);
				ram_req.wr_en   = 1'b1;
				ram_req.wr_addr = hd_q;
				ram_req.wr_data = w;
				state_d         = op_free_q ? sba_pkg::ST_DONE : sba_pkg::ST_SPLIT;
			end

			sba_pkg::ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					out_d.status       = res_status_q;
					out_d.block_addr   = res_addr_q;
					out_d.block_level  = res_level_q;
					out_d.pages_in_use = page_count_q;
					out_valid_d        = 1'b1;
					state_d            = sba_pkg::ST_IDLE;
				end
			end

			default: state_d = sba_pkg::ST_IDLE;
		endcase

		// An unlink ends by resuming the split on allocate or the merge on free.
		if (back_to_split)
			state_d = op_free_q ? sba_pkg::ST_MERGE : sba_pkg::ST_SPLIT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sba_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nonempty_q   <= '0;
			page_map_q   <= '0;
			page_count_q <= '0;
			out_valid_q  <= 1'b0;
			clr_cnt_q    <= '0;
		end else begin
			nonempty_q   <= nonempty_d;
			page_map_q   <= page_map_d;
			page_count_q <= page_count_d;
			out_valid_q  <= out_valid_d;
			clr_cnt_q    <= clr_cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		op_free_q    <= op_free_d;
		s_q          <= s_d;
		lv_q         <= lv_d;
		k_q          <= k_d;
		ul_slot_q    <= ul_slot_d;
		ul_lvl_q     <= ul_lvl_d;
		n_q          <= n_d;
		p_q          <= p_d;
		push_slot_q  <= push_slot_d;
		push_lvl_q   <= push_lvl_d;
		hd_q         <= hd_d;
		head_q       <= head_d;
		res_status_q <= res_status_d;
		res_addr_q   <= res_addr_d;
		res_level_q  <= res_level_d;
		out_q        <= out_d;
	end

	a_page_count: assert property (@(posedge clk) disable iff (!arst_n)
		32'(page_count_q) == $countones(page_map_q))
		else $error("page count disagrees with the page map");

	a_push_level: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sba_pkg::ST_PUSH) |-> (push_lvl_q < VW'(sba_pkg::TOP_LEVEL)))
		else $error("push to a level without a free list");

	a_unlink_level: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sba_pkg::ST_UL_DATA) |-> (ul_lvl_q < VW'(sba_pkg::TOP_LEVEL)))
		else $error("unlink from a level without a free list");

	a_split_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sba_pkg::ST_SPLIT) |-> (k_q >= lv_q))
		else $error("split went below the requested level");

	a_done_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sba_pkg::ST_DONE && !(out_valid_q && out_stall)) |=> out_valid_q)
		else $error("finished request did not reach the output register");

endmodule
